// File: src/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types, pipeline depths and the arctangent table of the curvature unit
// ----------------------------------------------------------------------------
package tpc_pkg;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [31:0] kappa_type;

   localparam int SqrtStages  = 32;
   localparam int DivStages   = 32;
   localparam int CordicSteps = 30;
   localparam int CordicDepth = CordicSteps + 4;
   localparam int FrontStages = 5;
   localparam int BackStages  = 3;
   localparam int PipeDepth   = FrontStages + CordicDepth + BackStages + DivStages;
   localparam int NormMsb     = 29;

   localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;

   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] val;
      case (idx)
         5'd0:    val = 31'd843314857;
         5'd1:    val = 31'd497837829;
         5'd2:    val = 31'd263043837;
         5'd3:    val = 31'd133525159;
         5'd4:    val = 31'd67021687;
         5'd5:    val = 31'd33543516;
         5'd6:    val = 31'd16775851;
         5'd7:    val = 31'd8388437;
         5'd8:    val = 31'd4194283;
         5'd9:    val = 31'd2097149;
         5'd10:   val = 31'd1048576;
         5'd11:   val = 31'd524288;
         5'd12:   val = 31'd262144;
         5'd13:   val = 31'd131072;
         5'd14:   val = 31'd65536;
         5'd15:   val = 31'd32768;
         5'd16:   val = 31'd16384;
         5'd17:   val = 31'd8192;
         5'd18:   val = 31'd4096;
         5'd19:   val = 31'd2048;
         5'd20:   val = 31'd1024;
         5'd21:   val = 31'd512;
         5'd22:   val = 31'd256;
         5'd23:   val = 31'd128;
         5'd24:   val = 31'd64;
         5'd25:   val = 31'd32;
         5'd26:   val = 31'd16;
         5'd27:   val = 31'd8;
         5'd28:   val = 31'd4;
         5'd29:   val = 31'd2;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: src/tpc_if.sv
// ----------------------------------------------------------------------------
// tpc channel interfaces
// point triple request, curvature response and mode write channels
// ----------------------------------------------------------------------------
interface tpc_req_if;
   logic                valid;
   logic                ready;
   tpc_pkg::coord_type  prev_x;
   tpc_pkg::coord_type  prev_y;
   tpc_pkg::coord_type  cur_x;
   tpc_pkg::coord_type  cur_y;
   tpc_pkg::coord_type  next_x;
   tpc_pkg::coord_type  next_y;

   modport source (output valid, prev_x, prev_y, cur_x, cur_y, next_x, next_y,
                   input ready);
   modport sink (input valid, prev_x, prev_y, cur_x, cur_y, next_x, next_y,
                 output ready);
endinterface

interface tpc_rsp_if;
   logic                valid;
   logic                ready;
   tpc_pkg::kappa_type  kappa;
   logic                degenerate;

   modport source (output valid, kappa, degenerate, input ready);
   modport sink (input valid, kappa, degenerate, output ready);
endinterface

interface tpc_csr_if;
   logic valid;
   logic ready;
   logic curvature_mode;

   modport source (output valid, curvature_mode, input ready);
   modport sink (input valid, curvature_mode, output ready);
endinterface

// File: src/tpc_isqrt.sv
// ----------------------------------------------------------------------------
// tpc_isqrt
// pipelined floor square root, 64-bit radicand, two radicand bits per stage
// ----------------------------------------------------------------------------
module tpc_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);
   import tpc_pkg::*;

   logic [63:0] v_ff    [SqrtStages];
   logic [34:0] r_ff    [SqrtStages];
   logic [31:0] root_ff [SqrtStages];

   for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
      logic [63:0] vi;
      logic [34:0] ri;
      logic [31:0] qi;
      logic [34:0] r2;
      logic [34:0] trial;
      logic        ge;

      if (g == 0) begin : g_first
         assign vi = rad;
         assign ri = '0;
         assign qi = '0;
      end else begin : g_next
         assign vi = v_ff[g-1];
         assign ri = r_ff[g-1];
         assign qi = root_ff[g-1];
      end

      assign r2    = {ri[32:0], vi[63:62]};
      assign trial = {1'b0, qi, 2'b01};
      assign ge    = r2 >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[g]    <= {vi[61:0], 2'b00};
            r_ff[g]    <= ge ? r2 - trial : r2;
            root_ff[g] <= {qi[30:0], ge};
         end
      end
   end

   assign root = root_ff[SqrtStages-1];

endmodule

// File: src/tpc_div.sv
// ----------------------------------------------------------------------------
// tpc_div
// pipelined restoring divider, quotient capped at 2^31, one bit per stage
// ----------------------------------------------------------------------------
module tpc_div (
   input  logic        clock,
   input  logic        en,
   input  logic [94:0] num,
   input  logic [95:0] den,
   output logic [31:0] quot
);
   import tpc_pkg::*;

   logic [94:0]          n_ff   [DivStages];
   logic [95:0]          d_ff   [DivStages];
   logic [DivStages-2:0] q_ff   [DivStages];
   logic                 cap_ff [DivStages];

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]   <= num;
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         cap_ff[0] <= {32'b0, num[94:31]} >= den;
      end
   end

   for (genvar g = 1; g < DivStages; g++) begin : g_stage
      logic [95:0] hi;
      logic        ge;

      assign hi = 96'(n_ff[g-1] >> (DivStages - 1 - g));
      assign ge = hi >= d_ff[g-1];

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[g]   <= ge ? n_ff[g-1] - 95'(d_ff[g-1] << (DivStages - 1 - g))
                            : n_ff[g-1];
            d_ff[g]   <= d_ff[g-1];
            q_ff[g]   <= {q_ff[g-1][DivStages-3:0], ge};
            cap_ff[g] <= cap_ff[g-1];
         end
      end
   end

   assign quot = cap_ff[DivStages-1] ? {1'b1, {(DivStages-1){1'b0}}}
                                      : {1'b0, q_ff[DivStages-1]};

endmodule

// File: src/three_point_curvature_top.sv
// ----------------------------------------------------------------------------
// three_point_curvature_top
// signed curvature of a front marker from its two neighbours, by circumradius
// or by turning angle over mean segment length
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  req_bus   in   prev/cur/next x,y, signed Q24.8
//  rsp_bus   out  kappa Q8.24 saturated, degenerate flag
//  csr_bus   in   curvature_mode (0 circumradius, 1 turning angle)
//
//  one beat per cycle while the two-entry output buffer is not full
//  built from 32-stage square root, 30-step angle pipeline, 32-stage divider
//  reset clears stage valid bits, output buffer valid flags and mode
//  a held response freezes the pipeline once the two-entry output buffer fills
// ----------------------------------------------------------------------------
module three_point_curvature_top (
   input  logic      clock,
   input  logic      reset,
   tpc_req_if.sink   req_bus,
   tpc_rsp_if.source rsp_bus,
   tpc_csr_if.sink   csr_bus
);
   import tpc_pkg::*;

   typedef struct packed {
      logic        degen;
      logic        neg;
      logic        crs_zero;
      logic [60:0] crs_mag;
      logic [1:0]  sh;
   } sb_type;

   typedef struct packed {
      logic degen;
      logic neg;
      logic zero;
   } ds_type;

   logic mode_ff;
   logic en;
   logic [PipeDepth-1:0] vld_ff;

   // mode register
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         mode_ff <= csr_bus.curvature_mode;
      end
   end

   logic main_v_ff, skid_v_ff;
   assign en            = !skid_v_ff;
   assign req_bus.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PipeDepth-2:0], req_bus.valid};
      end
   end

   // stage 1: segment vectors
   logic signed [32:0] s1_d_ff [4];
   logic               s1_degen_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_d_ff[0]  <= 33'(req_bus.cur_x) - 33'(req_bus.prev_x);
         s1_d_ff[1]  <= 33'(req_bus.cur_y) - 33'(req_bus.prev_y);
         s1_d_ff[2]  <= 33'(req_bus.next_x) - 33'(req_bus.cur_x);
         s1_d_ff[3]  <= 33'(req_bus.next_y) - 33'(req_bus.cur_y);
         s1_degen_ff <= (req_bus.cur_x == req_bus.prev_x && req_bus.cur_y == req_bus.prev_y)
                     || (req_bus.next_x == req_bus.cur_x && req_bus.next_y == req_bus.cur_y);
      end
   end

   // stage 2: magnitudes and range shift
   logic [32:0] s2_mag_in  [4];
   logic [32:0] s2_mag_ff  [4];
   logic        s2_sign_ff [4];
   logic [1:0]  s2_sh_in, s2_sh_ff;
   logic        s2_degen_ff;

   always_comb begin
      logic [32:0] mor;
      mor = '0;
      for (int k = 0; k < 4; k++) begin
         s2_mag_in[k] = s1_d_ff[k][32] ? unsigned'(-s1_d_ff[k]) : unsigned'(s1_d_ff[k]);
         mor          = mor | s2_mag_in[k];
      end
      if (mor[32]) begin
         s2_sh_in = 2'd3;
      end else if (mor[31]) begin
         s2_sh_in = 2'd2;
      end else if (mor[30]) begin
         s2_sh_in = 2'd1;
      end else begin
         s2_sh_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            s2_mag_ff[k]  <= s2_mag_in[k];
            s2_sign_ff[k] <= s1_d_ff[k][32];
         end
         s2_sh_ff    <= s2_sh_in;
         s2_degen_ff <= s1_degen_ff;
      end
   end

   // stage 3: scaled vectors and chord
   logic signed [30:0] s3_e_in [4];
   logic signed [30:0] s3_e_ff [4];
   logic signed [31:0] s3_cx_in, s3_cy_in, s3_cx_ff, s3_cy_ff;
   logic [1:0]         s3_sh_ff;
   logic               s3_degen_ff;

   always_comb begin
      logic [32:0] t;
      t = '0;
      for (int k = 0; k < 4; k++) begin
         t          = s2_mag_ff[k] >> s2_sh_ff;
         s3_e_in[k] = s2_sign_ff[k] ? -signed'(t[30:0]) : signed'(t[30:0]);
      end
      s3_cx_in = 32'(s3_e_in[0]) + 32'(s3_e_in[2]);
      s3_cy_in = 32'(s3_e_in[1]) + 32'(s3_e_in[3]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_e_ff     <= s3_e_in;
         s3_cx_ff    <= s3_cx_in;
         s3_cy_ff    <= s3_cy_in;
         s3_sh_ff    <= s2_sh_ff;
         s3_degen_ff <= s2_degen_ff;
      end
   end

   // stage 4: products
   logic signed [61:0] s4_p_ff  [8];
   logic signed [63:0] s4_cq_ff [2];
   logic [1:0]         s4_sh_ff;
   logic               s4_degen_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_p_ff[0]  <= 62'(s3_e_ff[0]) * 62'(s3_e_ff[3]);
         s4_p_ff[1]  <= 62'(s3_e_ff[1]) * 62'(s3_e_ff[2]);
         s4_p_ff[2]  <= 62'(s3_e_ff[0]) * 62'(s3_e_ff[2]);
         s4_p_ff[3]  <= 62'(s3_e_ff[1]) * 62'(s3_e_ff[3]);
         s4_p_ff[4]  <= 62'(s3_e_ff[0]) * 62'(s3_e_ff[0]);
         s4_p_ff[5]  <= 62'(s3_e_ff[1]) * 62'(s3_e_ff[1]);
         s4_p_ff[6]  <= 62'(s3_e_ff[2]) * 62'(s3_e_ff[2]);
         s4_p_ff[7]  <= 62'(s3_e_ff[3]) * 62'(s3_e_ff[3]);
         s4_cq_ff[0] <= 64'(s3_cx_ff) * 64'(s3_cx_ff);
         s4_cq_ff[1] <= 64'(s3_cy_ff) * 64'(s3_cy_ff);
         s4_sh_ff    <= s3_sh_ff;
         s4_degen_ff <= s3_degen_ff;
      end
   end

   // stage 5: cross, dot, squared lengths
   logic signed [61:0] s5_crs_ff, s5_dot_ff;
   logic [63:0]        s5_asq_ff, s5_bsq_ff, s5_csq_ff;
   logic [1:0]         s5_sh_ff;
   logic               s5_degen_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s5_crs_ff   <= s4_p_ff[0] - s4_p_ff[1];
         s5_dot_ff   <= s4_p_ff[2] + s4_p_ff[3];
         s5_asq_ff   <= {2'b00, unsigned'(s4_p_ff[4] + s4_p_ff[5])};
         s5_bsq_ff   <= {2'b00, unsigned'(s4_p_ff[6] + s4_p_ff[7])};
         s5_csq_ff   <= unsigned'(s4_cq_ff[0]) + unsigned'(s4_cq_ff[1]);
         s5_sh_ff    <= s4_sh_ff;
         s5_degen_ff <= s4_degen_ff;
      end
   end

   // lengths
   logic [31:0] sq_a, sq_b, sq_c;
   logic [31:0] sq1_a_ff, sq1_b_ff, sq1_c_ff, sq2_a_ff, sq2_b_ff, sq2_c_ff;

   tpc_isqrt u_sqrt_a (.clock(clock), .en(en), .rad(s5_asq_ff), .root(sq_a));
   tpc_isqrt u_sqrt_b (.clock(clock), .en(en), .rad(s5_bsq_ff), .root(sq_b));
   tpc_isqrt u_sqrt_c (.clock(clock), .en(en), .rad(s5_csq_ff), .root(sq_c));

   always_ff @(posedge clock) begin
      if (en) begin
         sq1_a_ff <= sq_a;
         sq1_b_ff <= sq_b;
         sq1_c_ff <= sq_c;
         sq2_a_ff <= sq1_a_ff;
         sq2_b_ff <= sq1_b_ff;
         sq2_c_ff <= sq1_c_ff;
      end
   end

   // sideband alongside lengths and angle
   sb_type sb_in;
   sb_type sb_ff [CordicDepth];

   always_comb begin
      sb_in.degen    = s5_degen_ff;
      sb_in.neg      = !s5_crs_ff[61] && s5_crs_ff != '0;
      sb_in.crs_zero = s5_crs_ff == '0;
      sb_in.crs_mag  = s5_crs_ff[61] ? 61'(unsigned'(-s5_crs_ff)) : 61'(unsigned'(s5_crs_ff));
      sb_in.sh       = s5_sh_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= sb_in;
         for (int k = 1; k < CordicDepth; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // turning angle: quadrant fold, normalize, vectoring steps
   logic [61:0] c0_x_ff, c0_y_ff;
   logic        c0_half_ff, c0_nz_ff;
   logic [61:0] c1_x_ff, c1_y_ff;
   logic [5:0]  c1_p_in, c1_p_ff;
   logic        c1_half_ff, c1_nz_ff;
   logic signed [33:0] c2_x_in, c2_y_in, c2_x_ff, c2_y_ff, c2_z_ff;
   logic        c2_nz_ff;
   logic signed [33:0] k_x_ff [CordicSteps];
   logic signed [33:0] k_y_ff [CordicSteps];
   logic signed [33:0] k_z_ff [CordicSteps];
   logic        k_nz_ff [CordicSteps];
   logic [31:0] theta_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (s5_dot_ff[61]) begin
            c0_x_ff <= {1'b0, sb_in.crs_mag};
            c0_y_ff <= unsigned'(-s5_dot_ff);
         end else begin
            c0_x_ff <= unsigned'(s5_dot_ff);
            c0_y_ff <= {1'b0, sb_in.crs_mag};
         end
         c0_half_ff <= s5_dot_ff[61];
         c0_nz_ff   <= s5_dot_ff != '0 || !sb_in.crs_zero;
      end
   end

   always_comb begin
      logic [61:0] bits;
      bits    = c0_x_ff | c0_y_ff;
      c1_p_in = '0;
      for (int i = 0; i < 62; i++) begin
         if (bits[i]) begin
            c1_p_in = 6'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_x_ff    <= c0_x_ff;
         c1_y_ff    <= c0_y_ff;
         c1_p_ff    <= c1_p_in;
         c1_half_ff <= c0_half_ff;
         c1_nz_ff   <= c0_nz_ff;
      end
   end

   always_comb begin
      logic [61:0] sx, sy;
      if (c1_p_ff >= 6'(NormMsb)) begin
         sx = c1_x_ff >> (c1_p_ff - 6'(NormMsb));
         sy = c1_y_ff >> (c1_p_ff - 6'(NormMsb));
      end else begin
         sx = c1_x_ff << (6'(NormMsb) - c1_p_ff);
         sy = c1_y_ff << (6'(NormMsb) - c1_p_ff);
      end
      c2_x_in = signed'({4'b0000, sx[29:0]});
      c2_y_in = signed'({4'b0000, sy[29:0]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_x_ff  <= c2_x_in;
         c2_y_ff  <= c2_y_in;
         c2_z_ff  <= c1_half_ff ? HalfPiQ30 : '0;
         c2_nz_ff <= c1_nz_ff;
      end
   end

   for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
      logic signed [33:0] xi, yi, zi, xs, ys, at;
      logic               nzi;

      if (g == 0) begin : g_first
         assign xi  = c2_x_ff;
         assign yi  = c2_y_ff;
         assign zi  = c2_z_ff;
         assign nzi = c2_nz_ff;
      end else begin : g_next
         assign xi  = k_x_ff[g-1];
         assign yi  = k_y_ff[g-1];
         assign zi  = k_z_ff[g-1];
         assign nzi = k_nz_ff[g-1];
      end

      assign xs = xi >>> g;
      assign ys = yi >>> g;
      assign at = signed'({3'b000, atan_q30(5'(g))});

      always_ff @(posedge clock) begin
         if (en) begin
            if (!yi[33]) begin
               k_x_ff[g] <= xi + ys;
               k_y_ff[g] <= yi - xs;
               k_z_ff[g] <= zi + at;
            end else begin
               k_x_ff[g] <= xi - ys;
               k_y_ff[g] <= yi + xs;
               k_z_ff[g] <= zi - at;
            end
            k_nz_ff[g] <= nzi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (!k_nz_ff[CordicSteps-1] || k_z_ff[CordicSteps-1][33]) begin
            theta_ff <= '0;
         end else begin
            theta_ff <= k_z_ff[CordicSteps-1][31:0];
         end
      end
   end

   // back end: numerator and denominator build
   sb_type      t1_sb_ff;
   logic [61:0] t1_ab_ff;
   logic [31:0] t1_apb_ff, t1_c_ff, t1_theta_ff;
   logic [62:0] t2_plo_ff, t2_phi_ff;
   logic [34:0] t2_den1_ff;
   logic [94:0] t2_num_ff, t3_num_ff;
   logic        t2_zero_ff, t2_degen_ff, t2_neg_ff, t2_mode_ff;
   logic [1:0]  t2_sh_ff;
   logic [95:0] t3_den_ff;
   ds_type      t3_ds_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t1_sb_ff    <= sb_ff[CordicDepth-1];
         t1_ab_ff    <= 62'(sq2_a_ff[30:0]) * 62'(sq2_b_ff[30:0]);
         t1_apb_ff   <= 32'(sq2_a_ff[30:0]) + 32'(sq2_b_ff[30:0]);
         t1_c_ff     <= sq2_c_ff;
         t1_theta_ff <= theta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_plo_ff   <= 63'(t1_ab_ff[30:0]) * 63'(t1_c_ff);
         t2_phi_ff   <= 63'(t1_ab_ff[61:31]) * 63'(t1_c_ff);
         t2_den1_ff  <= 35'(t1_apb_ff) << t1_sb_ff.sh;
         t2_mode_ff  <= mode_ff;
         if (mode_ff) begin
            t2_num_ff  <= 95'({t1_theta_ff, 3'b000});
            t2_zero_ff <= t1_apb_ff == '0;
         end else begin
            t2_num_ff  <= 95'({t1_sb_ff.crs_mag, 33'b0});
            t2_zero_ff <= t1_sb_ff.crs_zero || t1_ab_ff == '0 || t1_c_ff == '0;
         end
         t2_sh_ff    <= t1_sb_ff.sh;
         t2_degen_ff <= t1_sb_ff.degen;
         t2_neg_ff   <= t1_sb_ff.neg;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (t2_mode_ff) begin
            t3_den_ff <= 96'(t2_den1_ff);
         end else begin
            t3_den_ff <= (96'(t2_plo_ff) + {2'b00, t2_phi_ff, 31'b0}) << t2_sh_ff;
         end
         t3_num_ff      <= t2_num_ff;
         t3_ds_ff.degen <= t2_degen_ff;
         t3_ds_ff.neg   <= t2_neg_ff;
         t3_ds_ff.zero  <= t2_zero_ff;
      end
   end

   // division and sign
   logic [31:0] div_q;
   ds_type      ds_ff [DivStages];

   tpc_div u_div (.clock(clock), .en(en), .num(t3_num_ff), .den(t3_den_ff), .quot(div_q));

   always_ff @(posedge clock) begin
      if (en) begin
         ds_ff[0] <= t3_ds_ff;
         for (int k = 1; k < DivStages; k++) begin
            ds_ff[k] <= ds_ff[k-1];
         end
      end
   end

   ds_type    tail_ds;
   logic [31:0] tail_mag;
   kappa_type tail_kappa;
   logic      push;

   always_comb begin
      tail_ds  = ds_ff[DivStages-1];
      tail_mag = tail_ds.zero ? '0 : div_q;
      if (tail_ds.degen) begin
         tail_kappa = '0;
      end else if (tail_ds.neg) begin
         tail_kappa = -signed'(tail_mag);
      end else if (tail_mag[31]) begin
         tail_kappa = {1'b0, {31{1'b1}}};
      end else begin
         tail_kappa = signed'(tail_mag);
      end
   end

   assign push = en && vld_ff[PipeDepth-1];

   // two-entry output buffer
   kappa_type main_kappa_ff, main_kappa_in, skid_kappa_ff, skid_kappa_in;
   logic      main_degen_ff, main_degen_in, skid_degen_ff, skid_degen_in;
   logic      main_v_in, skid_v_in;

   always_comb begin
      main_kappa_in = main_kappa_ff;
      main_degen_in = main_degen_ff;
      main_v_in     = main_v_ff;
      skid_kappa_in = skid_kappa_ff;
      skid_degen_in = skid_degen_ff;
      skid_v_in     = skid_v_ff;
      if (main_v_ff && rsp_bus.ready) begin
         if (skid_v_ff) begin
            main_kappa_in = skid_kappa_ff;
            main_degen_in = skid_degen_ff;
            skid_v_in     = 1'b0;
         end else begin
            main_v_in = 1'b0;
         end
      end
      if (push) begin
         if (!main_v_in) begin
            main_kappa_in = tail_kappa;
            main_degen_in = tail_ds.degen;
            main_v_in     = 1'b1;
         end else begin
            skid_kappa_in = tail_kappa;
            skid_degen_in = tail_ds.degen;
            skid_v_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_kappa_ff <= main_kappa_in;
      main_degen_ff <= main_degen_in;
      skid_kappa_ff <= skid_kappa_in;
      skid_degen_ff <= skid_degen_in;
   end

   assign rsp_bus.valid      = main_v_ff;
   assign rsp_bus.kappa      = main_kappa_ff;
   assign rsp_bus.degenerate = main_degen_ff;

endmodule

// File: sim/tb_three_point_curvature_top.sv
// ----------------------------------------------------------------------------
// tb_three_point_curvature_top
// drives point triples through the curvature unit in both modes, predicts
// kappa and the degenerate flag with an integer model and checks each beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class curvature_scoreboard;
   bit       mode;
   int       errors;
   bit signed [31:0] kappa_q[$];
   bit       degen_q[$];

   function automatic longint tshift(longint v, int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
   endfunction

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned root(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function automatic longint turn_angle(longint dot, longint crs);
      longint x, y, z, t, xs, ys;
      x = dot;
      y = crs;
      z = 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = 1686629713;
      end
      while (x >= (64'sd1 << 30) || y >= (64'sd1 << 30)) begin
         x = x >>> 1;
         y = y >>> 1;
      end
      while (x < (64'sd1 << 29) && y < (64'sd1 << 29)) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < 30; i++) begin
         xs = fshift(x, i);
         ys = fshift(y, i);
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += longint'(tpc_pkg::atan_q30(i[4:0]));
         end else begin
            x -= ys;
            y += xs;
            z -= longint'(tpc_pkg::atan_q30(i[4:0]));
         end
      end
      return z < 0 ? 0 : z;
   endfunction

   function void note_triple(input bit signed [31:0] p[6]);
      longint d1x, d1y, d2x, d2y, crs, dot, cx, cy, theta;
      longint unsigned m, mg, a, b, c, den_s;
      bit [159:0] num, den;
      int s;
      bit neg;
      longint kap;
      d1x = longint'(p[2]) - longint'(p[0]);
      d1y = longint'(p[3]) - longint'(p[1]);
      d2x = longint'(p[4]) - longint'(p[2]);
      d2y = longint'(p[5]) - longint'(p[3]);
      if ((d1x == 0 && d1y == 0) || (d2x == 0 && d2y == 0)) begin
         kappa_q.push_back(0);
         degen_q.push_back(1);
         return;
      end
      m = 0;
      if ((d1x < 0 ? -d1x : d1x) > m) m = d1x < 0 ? -d1x : d1x;
      if ((d1y < 0 ? -d1y : d1y) > m) m = d1y < 0 ? -d1y : d1y;
      if ((d2x < 0 ? -d2x : d2x) > m) m = d2x < 0 ? -d2x : d2x;
      if ((d2y < 0 ? -d2y : d2y) > m) m = d2y < 0 ? -d2y : d2y;
      s = 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      d1x = tshift(d1x, s);
      d1y = tshift(d1y, s);
      d2x = tshift(d2x, s);
      d2y = tshift(d2y, s);
      crs = d1x * d2y - d1y * d2x;
      neg = crs > 0;
      a = root(d1x * d1x + d1y * d1y);
      b = root(d2x * d2x + d2y * d2y);
      mg = 0;
      if (mode == 0) begin
         if (crs != 0) begin
            cx = d1x + d2x;
            cy = d1y + d2y;
            c = root(longint'(cx * cx) + longint'(cy * cy));
            num = 160'(crs < 0 ? -crs : crs) << 33;
            den = (160'(a * b) * 160'(c)) << s;
            if (den != 0) begin
               num = num / den;
               mg = num > (160'd1 << 31) ? (64'd1 << 31) : longint'(num);
            end
         end
      end else begin
         dot = d1x * d2x + d1y * d2y;
         theta = 0;
         den_s = (a + b) << s;
         if (dot != 0 || crs != 0) theta = turn_angle(dot, crs < 0 ? -crs : crs);
         if (den_s != 0) mg = (longint'(theta) * 8) / den_s;
         if (mg > (64'd1 << 31)) mg = 64'd1 << 31;
      end
      if (neg) kap = -longint'(mg);
      else kap = mg > 64'h7FFFFFFF ? 64'h7FFFFFFF : longint'(mg);
      kappa_q.push_back(kap[31:0]);
      degen_q.push_back(0);
   endfunction

   function void check_curvature(bit signed [31:0] kappa, bit degen);
      if (kappa_q.size() == 0) begin
         $error("unexpected response beat kappa=%0d", kappa);
         errors++;
         return;
      end
      if (kappa_q[0] !== kappa) begin
         $error("kappa expected %0d actual %0d", kappa_q[0], kappa);
         errors++;
      end
      if (degen_q[0] !== degen) begin
         $error("degenerate expected %0d actual %0d", degen_q[0], degen);
         errors++;
      end
      void'(kappa_q.pop_front());
      void'(degen_q.pop_front());
   endfunction
endclass

module tb_three_point_curvature_top;
   logic clock = 0;
   logic reset = 1;
   int   send_idle = 0;
   int   recv_stall = 0;
   longint cycles = 0;
   curvature_scoreboard sb;

   tpc_req_if req_bus();
   tpc_rsp_if rsp_bus();
   tpc_csr_if csr_bus();

   three_point_curvature_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always #10 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.prev_x = 0;
      req_bus.prev_y = 0;
      req_bus.cur_x = 0;
      req_bus.cur_y = 0;
      req_bus.next_x = 0;
      req_bus.next_y = 0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0;
      csr_bus.curvature_mode = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_curvature(rsp_bus.kappa, rsp_bus.degenerate);

   always @(negedge clock)
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_stall);

   // valid stays high after a beat; drain lowers it, as does the next call when it inserts idle gaps
   task automatic send_triple(input bit signed [31:0] p[6]);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.prev_x <= p[0];
      req_bus.prev_y <= p[1];
      req_bus.cur_x <= p[2];
      req_bus.cur_y <= p[3];
      req_bus.next_x <= p[4];
      req_bus.next_y <= p[5];
      do @(posedge clock); while (!req_bus.ready);
      sb.note_triple(p);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (sb.kappa_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_mode(input bit mode_bit);
      drain();
      csr_bus.valid <= 1;
      csr_bus.curvature_mode <= mode_bit;
      do @(posedge clock); while (!csr_bus.ready);
      sb.mode = mode_bit;
      @(negedge clock);
      csr_bus.valid <= 0;
   endtask

   function automatic bit signed [31:0] rand_coord(int kind);
      case (kind)
         0: return $urandom;
         1: return $signed($urandom_range(4000)) - 2000;
         2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $signed($urandom_range(1 << 20)) - (1 << 19);
      endcase
   endfunction

   task automatic random_triples(int n);
      bit signed [31:0] p[6];
      int kind;
      repeat (n) begin
         kind = $urandom_range(3);
         foreach (p[i]) p[i] = rand_coord(kind == 2 ? $urandom_range(2) : kind);
         case ($urandom_range(9))
            0: begin p[2] = p[0]; p[3] = p[1]; end
            1: begin p[4] = p[2]; p[5] = p[3]; end
            2: begin p[4] = p[2] + (p[2] - p[0]); p[5] = p[3] + (p[3] - p[1]); end
            3: begin p[4] = p[0]; p[5] = p[1]; end
            default: ;
         endcase
         send_triple(p);
      end
   endtask

   task automatic directed_triples();
      bit signed [31:0] p[6];
      p = '{0, 0, 256, 0, 512, 0};             send_triple(p);
      p = '{0, 0, 256, 0, 256, 0};             send_triple(p);
      p = '{0, 0, 0, 0, 256, 0};               send_triple(p);
      p = '{0, 0, 256, 0, 0, 0};               send_triple(p);
      p = '{0, 0, 256, 0, 256, 256};           send_triple(p);
      p = '{0, 0, 256, 0, 256, -256};          send_triple(p);
      p = '{0, 0, 1, 0, 1, 1};                 send_triple(p);
      p = '{0, 0, 1, 1, 2, 0};                 send_triple(p);
      p = '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h80000000, 32'h7FFFFFFF};       send_triple(p);
      p = '{32'h7FFFFFFF, 0, 32'h80000000, 0, 32'h7FFFFFFF, 1}; send_triple(p);
      p = '{-1, -1, 0, 0, 1, 1};               send_triple(p);
      p = '{-1, -1, -1, -1, 5, 5};             send_triple(p);
      p = '{0, 0, 2, 0, 0, 1};                 send_triple(p);
      p = '{0, 0, 1, 0, 1, 0};                 send_triple(p);
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int ph = 0; ph < 8; ph++) begin
         write_mode(ph[0]);
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 71; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 71; end
            default: begin send_idle = 18; recv_stall = 18; end
         endcase
         if (ph < 2) directed_triples();
         random_triples(120);
         drain();
         random_triples(120);
      end
      drain();
      if (sb.errors == 0 && sb.kappa_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
